[hw/rtl/thp_pkg.sv]
package thp_pkg;

  localparam int unsigned NameCapacityDefault = 256;
  localparam logic [63:0] SyncWord = 64'hDEADBEEFCAFEBABE;
  localparam logic [31:0] ExpFileNumReset = 32'd1;
  localparam logic [63:0] MaxFileSizeReset = 64'd10737418240;
  localparam logic [31:0] MaxStreamCountReset = 32'd16;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgExpFileNum = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxFileSize = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxStreamCount = 2'd2;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StSync    = 3'd1,
    StFnum    = 3'd2,
    StSize    = 3'd3,
    StStreams = 3'd4,
    StName    = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]  name_length;
    logic [31:0] stream_count;
    logic [63:0] size_bytes;
    status_e     status;
    logic        header_done;
    logic [7:0]  name_char;
    logic        name_valid;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);
  localparam int unsigned OutDataW = 128;

endpackage

[hw/rtl/thp_front.sv]
module thp_front #(
  parameter int unsigned NameCapacity = thp_pkg::NameCapacityDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [63:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            in_byte_i,
  input  logic                  in_restart_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output thp_pkg::result_t      res_o
);
  import thp_pkg::*;

  typedef enum logic [2:0] {
    PhSync, PhFnum, PhSize, PhStreams, PhNlen, PhName
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic [63:0] size_q, size_d;
  logic [31:0] streams_q, streams_d;
  logic [7:0]  nlen_q, nlen_d;
  logic [7:0]  left_q, left_d;
  logic [31:0] exp_q;
  logic [63:0] max_size_q;
  logic [31:0] max_str_q;

  logic        emit;
  logic        e_nv, e_done;
  status_e     e_st;
  logic [63:0] v;
  logic [2:0]  lastcnt;
  logic [7:0]  left_dec;
  phase_e      ph;
  logic        fire;

  assign fire = in_valid_i && in_ready_o;
  assign in_ready_o = !res_valid_o || res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q      <= ExpFileNumReset;
      max_size_q <= MaxFileSizeReset;
      max_str_q  <= MaxStreamCountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgExpFileNum:     exp_q <= cfg_data_i[31:0];
        CfgMaxFileSize:    max_size_q <= cfg_data_i;
        CfgMaxStreamCount: max_str_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ph = in_restart_i ? PhSync : phase_q;
    phase_d = phase_q;
    cnt_d = in_restart_i ? 3'd0 : cnt_q;
    shift_d = in_restart_i ? 64'd0 : shift_q;
    size_d = size_q;
    streams_d = streams_q;
    nlen_d = nlen_q;
    left_d = left_q;
    emit = 1'b0;
    e_nv = 1'b0;
    e_done = 1'b0;
    e_st = StOk;
    v = {shift_d[55:0], in_byte_i};
    lastcnt = (ph == PhSync || ph == PhSize) ? 3'd7 : 3'd3;
    left_dec = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
    if (ph == PhName) begin
      emit = 1'b1;
      e_nv = 1'b1;
      left_d = left_dec;
      if (left_dec == 8'd0) begin
        e_done = 1'b1;
        phase_d = PhSync;
        cnt_d = 3'd0;
        shift_d = 64'd0;
      end
    end else if (cnt_d != lastcnt) begin
      phase_d = ph;
      cnt_d = cnt_d + 3'd1;
      shift_d = v;
    end else begin
      cnt_d = 3'd0;
      shift_d = 64'd0;
      phase_d = PhSync;
      unique case (ph)
        PhSync: begin
          if (v != SyncWord) begin emit = 1'b1; e_done = 1'b1; e_st = StSync; end
          else phase_d = PhFnum;
        end
        PhFnum: begin
          if (v[31:0] != exp_q) begin emit = 1'b1; e_done = 1'b1; e_st = StFnum; end
          else phase_d = PhSize;
        end
        PhSize: begin
          if (v == 64'd0 || v > max_size_q) begin
            emit = 1'b1; e_done = 1'b1; e_st = StSize;
          end else begin
            size_d = v;
            phase_d = PhStreams;
          end
        end
        PhStreams: begin
          if (v[31:0] == 32'd0 || v[31:0] > max_str_q) begin
            emit = 1'b1; e_done = 1'b1; e_st = StStreams;
          end else begin
            streams_d = v[31:0];
            phase_d = PhNlen;
          end
        end
        default: begin
          if ({32'd0, v[31:0]} >= 64'(NameCapacity)) begin
            emit = 1'b1; e_done = 1'b1; e_st = StName;
          end else begin
            nlen_d = v[7:0];
            left_d = v[7:0];
            if (v[7:0] == 8'd0) begin emit = 1'b1; e_done = 1'b1; end
            else phase_d = PhName;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSync;
      cnt_q       <= 3'd0;
      shift_q     <= 64'd0;
      size_q      <= 64'd0;
      streams_q   <= 32'd0;
      nlen_q      <= 8'd0;
      left_q      <= 8'd0;
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= (fire && emit) || (res_valid_o && !res_ready_i);
      if (fire) begin
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        shift_q   <= shift_d;
        size_q    <= size_d;
        streams_q <= streams_d;
        nlen_q    <= nlen_d;
        left_q    <= left_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_o.name_valid   <= e_nv;
      res_o.name_char    <= e_nv ? in_byte_i : 8'd0;
      res_o.header_done  <= e_done;
      res_o.status       <= e_st;
      res_o.size_bytes   <= (e_done && e_st == StOk) ? size_d : 64'd0;
      res_o.stream_count <= (e_done && e_st == StOk) ? streams_d : 32'd0;
      res_o.name_length  <= (e_done && e_st == StOk) ? nlen_d : 8'd0;
    end
  end

`ifndef ASSERT_OFF
  a_name_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhName |-> left_q != 8'd0) else $error("name phase with no bytes left");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result lost");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhFnum || phase_q == PhStreams || phase_q == PhNlen) |-> cnt_q < 3'd4)
    else $error("field count overrun");
`endif
endmodule

[hw/rtl/thp_back.sv]
module thp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  output logic             res_ready_o,
  input  thp_pkg::result_t res_i,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [thp_pkg::OutDataW-1:0] m_axis_tdata
);
  import thp_pkg::*;

  result_t buf_q [2];
  logic    wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign res_ready_o = cnt_q != 2'd2;
  assign push = res_valid_i && res_ready_o;
  assign pop = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata = {{(OutDataW - ResultW){1'b0}}, buf_q[rp_q]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= res_i;
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q) else $error("pointer skew");
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 && !push |=> !m_axis_tvalid) else $error("phantom word");
`endif
endmodule

[hw/rtl/transfer_header_parser.sv]
// channel   | dir | word (low bit up)
// s_axis    | in  | tdata: data_byte[7:0]; tuser: restart
// m_axis    | out | tdata: name_valid, name_char, header_done, status, size_bytes,
//           |     |        stream_count, name_length (117 bits, zero-filled to 128)
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// One byte per cycle unless a held result waits on a full output queue.
// A two-entry output queue lets input continue while the output side stalls.
// Reset clears the parse state and loads the register reset values.
module transfer_header_parser #(
  parameter int unsigned NameCapacity = thp_pkg::NameCapacityDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata   // see table
);
  import thp_pkg::*;

  logic    res_valid, res_ready;
  result_t res;

  thp_front #(.NameCapacity(NameCapacity)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_byte_i(s_axis_tdata), .in_restart_i(s_axis_tuser),
    .res_valid_o(res_valid), .res_ready_i(res_ready), .res_o(res)
  );

  thp_back u_back (
    .clk_i, .rst_ni, .res_valid_i(res_valid), .res_ready_o(res_ready), .res_i(res),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );
endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import thp_pkg::*;

  typedef enum logic [2:0] {
    PhSync    = 3'd0,
    PhFnum    = 3'd1,
    PhSize    = 3'd2,
    PhStreams = 3'd3,
    PhNlen    = 3'd4,
    PhName    = 3'd5
  } parse_phase_e;

  localparam int unsigned IdleLimit = 5000;

  class header_scoreboard;
    logic [31:0]  exp_fnum;
    logic [63:0]  max_size;
    logic [31:0]  max_streams;
    parse_phase_e phase;
    int unsigned  fcount;
    logic [63:0]  shift;
    logic [63:0]  held_size;
    logic [31:0]  held_streams;
    logic [7:0]   held_nlen;
    logic [7:0]   left;
    result_t      expected_q[$];
    int           errors;
    int           headers_ok;
    int           headers_bad;
    int           name_chars;

    function new();
      exp_fnum     = ExpFileNumReset;
      max_size     = MaxFileSizeReset;
      max_streams  = MaxStreamCountReset;
      held_size    = '0;
      held_streams = '0;
      held_nlen    = '0;
      left         = '0;
      errors       = 0;
      headers_ok   = 0;
      headers_bad  = 0;
      name_chars   = 0;
      start_field(PhSync);
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [63:0] d);
      case (idx)
        CfgExpFileNum:     exp_fnum = d[31:0];
        CfgMaxFileSize:    max_size = d;
        CfgMaxStreamCount: max_streams = d[31:0];
        default: ;
      endcase
    endfunction

    function void start_field(parse_phase_e p);
      phase  = p;
      fcount = 0;
      shift  = '0;
    endfunction

    function void push(logic nv, logic [7:0] ch, logic done, status_e st);
      result_t r;
      logic ok;
      ok            = done && (st == StOk);
      r.name_valid  = nv;
      r.name_char   = nv ? ch : 8'd0;
      r.header_done = done;
      r.status      = done ? st : StOk;
      r.size_bytes  = ok ? held_size : 64'd0;
      r.stream_count = ok ? held_streams : 32'd0;
      r.name_length = ok ? held_nlen : 8'd0;
      expected_q.push_back(r);
      if (nv) name_chars++;
      if (ok) headers_ok++;
      else if (done) headers_bad++;
    endfunction

    function void fail(status_e st);
      start_field(PhSync);
      push(1'b0, 8'd0, 1'b1, st);
    endfunction

    function void note_word(logic [7:0] b, logic rs);
      int unsigned len;
      if (rs) start_field(PhSync);
      if (phase > PhName) start_field(PhSync);
      if (phase == PhName) begin
        if (left != 0) left--;
        if (left == 0) begin
          start_field(PhSync);
          push(1'b1, b, 1'b1, StOk);
        end else begin
          push(1'b1, b, 1'b0, StOk);
        end
        return;
      end
      len   = (phase == PhSync || phase == PhSize) ? 8 : 4;
      shift = {shift[55:0], b};
      if (fcount + 1 < len) begin
        fcount++;
        return;
      end
      case (phase)
        PhSync: begin
          if (shift != SyncWord) fail(StSync);
          else start_field(PhFnum);
        end
        PhFnum: begin
          if (shift[31:0] != exp_fnum) fail(StFnum);
          else start_field(PhSize);
        end
        PhSize: begin
          if (shift == 0 || shift > max_size) fail(StSize);
          else begin
            held_size = shift;
            start_field(PhStreams);
          end
        end
        PhStreams: begin
          if (shift[31:0] == 0 || shift[31:0] > max_streams) fail(StStreams);
          else begin
            held_streams = shift[31:0];
            start_field(PhNlen);
          end
        end
        default: begin
          if (shift[31:0] >= NameCapacityDefault) fail(StName);
          else begin
            held_nlen = shift[7:0];
            left      = shift[7:0];
            if (left == 0) begin
              start_field(PhSync);
              push(1'b0, 8'd0, 1'b1, StOk);
            end else begin
              start_field(PhName);
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_word(logic [OutDataW-1:0] w);
      result_t got;
      result_t want;
      got = w[ResultW-1:0];
      if (w[OutDataW-1:ResultW] != '0) report("nonzero fill bits");
      if (expected_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = expected_q.pop_front();
      if (got.name_valid != want.name_valid)
        report($sformatf("name_valid %0b, want %0b", got.name_valid, want.name_valid));
      if (got.name_char != want.name_char)
        report($sformatf("name_char %h, want %h", got.name_char, want.name_char));
      if (got.header_done != want.header_done)
        report($sformatf("header_done %0b, want %0b", got.header_done, want.header_done));
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.size_bytes != want.size_bytes)
        report($sformatf("size_bytes %h, want %h", got.size_bytes, want.size_bytes));
      if (got.stream_count != want.stream_count)
        report($sformatf("stream_count %h, want %h", got.stream_count, want.stream_count));
      if (got.name_length != want.name_length)
        report($sformatf("name_length %0d, want %0d", got.name_length, want.name_length));
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [63:0]          cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;

  header_scoreboard sb;
  logic     hold_req;
  logic     no_idle;
  int       idle_cycles = 0;
  int       bytes_sent;
  logic [7:0] hdr_q[$];
  logic       rs_q[$];

  transfer_header_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tdata, s_axis_tuser);
    if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int g;
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
        held = 1'b1;
      end
      g = gap_len();
      if (g > 0) begin
        m_axis_tready = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  task automatic send_queue();
    int g;
    while (hdr_q.size() > 0) begin
      g = gap_len();
      if (g > 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      s_axis_tvalid = 1'b1;
      s_axis_tdata  = hdr_q.pop_front();
      s_axis_tuser  = rs_q.pop_front();
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      bytes_sent++;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic add_field(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) begin
      hdr_q.push_back(v[8*i +: 8]);
      rs_q.push_back(1'b0);
    end
  endtask

  task automatic send_header(logic [63:0] sync, logic [31:0] fnum, logic [63:0] size,
                             logic [31:0] streams, logic [31:0] nlen, logic rs,
                             int cut);
    add_field(sync, 8);
    add_field(fnum, 4);
    add_field(size, 8);
    add_field(streams, 4);
    add_field(nlen, 4);
    if (nlen < NameCapacityDefault)
      for (int i = 0; i < nlen; i++) begin
        hdr_q.push_back(8'($urandom_range(0, 255)));
        rs_q.push_back(1'b0);
      end
    rs_q[0] = rs;
    while (cut > 0 && hdr_q.size() > cut) begin
      void'(hdr_q.pop_back());
      void'(rs_q.pop_back());
    end
    send_queue();
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] d);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = d;
    sb.set_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_header();
    int          k;
    int          cut;
    logic [63:0] sync;
    logic [31:0] fnum;
    logic [63:0] size;
    logic [31:0] streams;
    logic [31:0] nlen;
    logic        rs;
    k       = $urandom_range(0, 99);
    cut     = 0;
    rs      = ($urandom_range(0, 3) == 0);
    sync    = SyncWord;
    fnum    = sb.exp_fnum;
    size    = ($urandom_range(0, 3) == 0) ? sb.max_size : 64'($urandom_range(1, 4096));
    if (size > sb.max_size) size = sb.max_size;
    streams = ($urandom_range(0, 3) == 0) ? sb.max_streams : 32'($urandom_range(1, 64));
    if (streams > sb.max_streams) streams = sb.max_streams;
    nlen    = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 8);
    if (k < 8) sync = sync ^ (64'd1 << $urandom_range(0, 63));
    else if (k < 14) fnum = fnum ^ 32'($urandom_range(1, 32'hFFFF_FFFF));
    else if (k < 20) size = ($urandom_range(0, 1) == 0) ? 64'd0 : sb.max_size + 64'd1;
    else if (k < 26) streams = ($urandom_range(0, 1) == 0) ? 32'd0 : sb.max_streams + 32'd1;
    else if (k < 31) nlen = ($urandom_range(0, 1) == 0) ? 32'd256 : {$urandom} | 32'h100;
    else if (k < 38) begin
      cut = $urandom_range(1, 30);
      send_header(sync, fnum, size, streams, nlen, rs, cut);
      sync = SyncWord;
      rs   = 1'b1;
      cut  = 0;
    end else if (k < 42) begin
      repeat ($urandom_range(1, 10)) begin
        hdr_q.push_back(8'($urandom_range(0, 255)));
        rs_q.push_back(1'($urandom_range(0, 1)));
      end
      send_queue();
      rs = 1'b1;
    end
    send_header(sync, fnum, size, streams, nlen, rs, cut);
  endtask

  initial begin
    sb            = new();
    hold_req      = 1'b0;
    no_idle       = 1'b0;
    bytes_sent    = 0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset register values: good, empty name, each failing check, restart
    send_header(SyncWord, 32'd1, 64'd1, 32'd1, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, MaxFileSizeReset, 32'd16, 32'd3, 1'b0, 0);
    send_header(64'hFFFF_FFFF_FFFF_FFFF, 32'd1, 64'd1, 32'd1, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd0, 64'd1, 32'd1, 32'd0, 1'b1, 0);
    send_header(SyncWord, 32'd1, 64'd0, 32'd1, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, MaxFileSizeReset + 1, 32'd1, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd0, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'hFFFF_FFFF, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd17, 32'd0, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd2, 32'd256, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd2, 32'hFFFF_FFFF, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd2, 32'd255, 1'b0, 0);
    send_header(SyncWord, 32'd1, 64'd5, 32'd2, 32'd10, 1'b0, 30);
    send_header(SyncWord, 32'd1, 64'd5, 32'd2, 32'd1, 1'b1, 0);
    drain();

    write_reg(CfgExpFileNum, 64'd0);
    write_reg(CfgMaxFileSize, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgMaxStreamCount, 64'hFFFF_FFFF);
    send_header(SyncWord, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd2, 1'b0, 0);
    drain();
    write_reg(CfgExpFileNum, 64'hFFFF_FFFF);
    write_reg(CfgMaxFileSize, 64'd1);
    write_reg(CfgMaxStreamCount, 64'd1);
    send_header(SyncWord, 32'hFFFF_FFFF, 64'd1, 32'd1, 32'd1, 1'b0, 0);
    send_header(SyncWord, 32'hFFFF_FFFF, 64'd2, 32'd1, 32'd1, 1'b0, 0);
    send_header(SyncWord, 32'hFFFF_FFFF, 64'd1, 32'd2, 32'd1, 1'b0, 0);
    drain();
    write_reg(CfgMaxFileSize, 64'd0);
    write_reg(CfgMaxStreamCount, 64'd0);
    send_header(SyncWord, 32'hFFFF_FFFF, 64'd1, 32'd1, 32'd0, 1'b0, 0);
    drain();
    write_reg(CfgMaxFileSize, 64'd1000);
    write_reg(CfgMaxStreamCount, 64'd0);
    send_header(SyncWord, 32'hFFFF_FFFF, 64'd1, 32'd1, 32'd0, 1'b0, 0);
    drain();

    for (int ph = 0; bytes_sent < 1000; ph++) begin
      write_reg(CfgExpFileNum, {32'd0, $urandom});
      write_reg(CfgMaxFileSize, ($urandom_range(0, 1) == 0) ? 64'd5000 : {$urandom, $urandom});
      write_reg(CfgMaxStreamCount, 64'($urandom_range(1, 100)));
      no_idle = (ph % 4 == 3);
      for (int h = 0; h < 8; h++) begin
        if (ph == 1 && h == 2) hold_req = 1'b1;
        random_header();
      end
      drain();
    end
    no_idle = 1'b0;

    drain();
    if (sb.expected_q.size() != 0) sb.report("results still outstanding at end");
    $display("covered %0d bytes: %0d headers accepted, %0d rejected, %0d name bytes",
             bytes_sent, sb.headers_ok, sb.headers_bad, sb.name_chars);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/thp_pkg.sv
hw/rtl/thp_front.sv
hw/rtl/thp_back.sv
hw/rtl/transfer_header_parser.sv
verif/tb_top.sv
